/* sv/utf8wd_pkg.sv */
//------------------------------------------------------------------------------
// utf8wd_pkg
// Types and constants shared by the UTF-8 window decoder modules.
//------------------------------------------------------------------------------
`default_nettype none

package utf8wd_pkg;

	localparam int unsigned LANES    = 4;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned WIN_W    = 32;
	localparam int unsigned CP_W     = 21;
	localparam int unsigned LEN_W    = 3;
	localparam int unsigned OFF_W    = 16;

	localparam logic [CP_W-1:0] UNICODE_TOP = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LOW    = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HIGH   = 21'h00DFFF;
	localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;
	localparam logic [WIN_W-1:0] SIX_BITS   = 32'h0000003F;

	// Lead and continuation bits that identify each form, one to four bytes.
	localparam logic [WIN_W-1:0] FORM_MASK [LANES] = '{
		32'h80000000, 32'hE0C00000, 32'hF0C0C000, 32'hF8C0C0C0
	};
	localparam logic [WIN_W-1:0] FORM_PATTERN [LANES] = '{
		32'h00000000, 32'hC0800000, 32'hE0808000, 32'hF0808080
	};
	// Smallest legal window of each form; anything below is overlong.
	localparam logic [WIN_W-1:0] FORM_FLOOR [LANES] = '{
		32'h00000000, 32'hC2800000, 32'hE0A08000, 32'hF0908080
	};

	typedef struct packed {
		logic            hit;   // window has this form's bit pattern
		logic            good;  // not overlong and a legal scalar value
		logic [CP_W-1:0] cp;
	} lane_res_t;

endpackage

`default_nettype wire

/* sv/utf8wd_in_if.sv */
//------------------------------------------------------------------------------
// utf8wd_in_if
// Input channel: a four-byte window and the offset of its first byte.
//------------------------------------------------------------------------------
`default_nettype none

interface utf8wd_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_first;
	logic [7:0]  byte_second;
	logic [7:0]  byte_third;
	logic [7:0]  byte_fourth;
	logic [15:0] start_offset;

	modport source (
		output valid, byte_first, byte_second, byte_third, byte_fourth, start_offset,
		input  ready
	);
	modport sink (
		input  valid, byte_first, byte_second, byte_third, byte_fourth, start_offset,
		output ready
	);
endinterface

`default_nettype wire

/* sv/utf8wd_out_if.sv */
//------------------------------------------------------------------------------
// utf8wd_out_if
// Output channel: one decoded code point per item.
//------------------------------------------------------------------------------
`default_nettype none

interface utf8wd_out_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic [2:0]  consumed_length;
	logic        replaced;
	logic [15:0] next_offset;

	modport source (
		output valid, code_point, consumed_length, replaced, next_offset,
		input  ready
	);
	modport sink (
		input  valid, code_point, consumed_length, replaced, next_offset,
		output ready
	);
endinterface

`default_nettype wire

/* sv/utf8_window_decoder.sv */
//------------------------------------------------------------------------------
// utf8_window_decoder
// Decodes one UTF-8 scalar value from a four-byte window per item.
//------------------------------------------------------------------------------
// The block takes one window per clock cycle while the result channel is not
// stalled, and returns one result per window. Four lanes test the one- to
// four-byte forms side by side and their findings are registered; a merge
// stage then selects the matching form and fills the output register. A zero
// first byte returns code point 0 with length 0; any malformed, overlong,
// surrogate or out-of-range sequence returns U+FFFD with length 1 and the
// replaced flag set. The next offset wraps at 2**OFFSET_BITS, at most 2**16.
`default_nettype none

module utf8_window_decoder
	import utf8wd_pkg::*;
#(
	parameter int unsigned OFFSET_BITS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	utf8wd_in_if.sink     window,
	utf8wd_out_if.source  result
);

	logic [BYTE_W-1:0] b1, b2, b3;
	logic [WIN_W-1:0]  win;
	lane_res_t         lane_res [LANES];

	logic              valid_s1;
	lane_res_t         lane_res_s1 [LANES];
	logic              at_end_s1;
	logic [OFF_W-1:0]  offset_s1;

	logic [CP_W-1:0]   m_cp;
	logic [LEN_W-1:0]  m_len;
	logic              m_rep;
	logic [OFF_W-1:0]  m_next;

	logic              valid_q;
	logic [CP_W-1:0]   cp_q;
	logic [LEN_W-1:0]  len_q;
	logic              rep_q;
	logic [OFF_W-1:0]  next_q;

	logic              out_free;

	// Every byte after the first zero byte reads as zero.
	always_comb begin
		b1  = (window.byte_first == '0) ? '0 : window.byte_second;
		b2  = (b1 == '0) ? '0 : window.byte_third;
		b3  = (b2 == '0) ? '0 : window.byte_fourth;
		win = {window.byte_first, b1, b2, b3};
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		utf8wd_lane #(.FORM(g)) u_lane (
			.win (win),
			.res (lane_res[g])
		);
	end

	assign out_free     = !valid_q || result.ready;
	assign window.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (window.ready) begin
				valid_s1 <= window.valid;
			end
			if (out_free) begin
				valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (window.ready) begin
			lane_res_s1 <= lane_res;
			at_end_s1   <= (window.byte_first == '0);
			offset_s1   <= window.start_offset;
		end
		if (out_free) begin
			cp_q   <= m_cp;
			len_q  <= m_len;
			rep_q  <= m_rep;
			next_q <= m_next;
		end
	end

	utf8wd_merge #(.OFFSET_BITS(OFFSET_BITS)) u_merge (
		.lanes           (lane_res_s1),
		.at_end          (at_end_s1),
		.start_offset    (offset_s1),
		.code_point      (m_cp),
		.consumed_length (m_len),
		.replaced        (m_rep),
		.next_offset     (m_next)
	);

	assign result.valid           = valid_q;
	assign result.code_point      = cp_q;
	assign result.consumed_length = len_q;
	assign result.replaced        = rep_q;
	assign result.next_offset     = next_q;

endmodule

`default_nettype wire

/* sv/utf8wd_lane.sv */
//------------------------------------------------------------------------------
// utf8wd_lane
// Tries one encoding form on the window: pattern, overlong and range checks,
// and assembly of the code point.
//------------------------------------------------------------------------------
`default_nettype none

module utf8wd_lane
	import utf8wd_pkg::*;
#(
	parameter int unsigned FORM = 0
) (
	input  wire logic [WIN_W-1:0] win,
	output lane_res_t             res
);

	localparam int unsigned SHIFT = (LANES - 1 - FORM) * 6;

	logic [WIN_W-1:0] payload;
	logic [24:0]      packed_bits;
	logic [24:0]      shifted;
	logic [CP_W-1:0]  cp;
	logic             in_range;

	always_comb begin
		payload     = win & ~FORM_MASK[FORM];
		// Drop the two marker bits of every continuation byte.
		packed_bits = 25'(payload & SIX_BITS)
			| 25'((payload & 32'h00003F00) >> 2)
			| 25'((payload & 32'h003F0000) >> 4)
			| 25'((payload & 32'h7F000000) >> 6);
		shifted     = packed_bits >> SHIFT;
		cp          = shifted[CP_W-1:0];
		in_range    = (cp < SURR_LOW) || ((cp > SURR_HIGH) && (cp <= UNICODE_TOP));

		res.hit  = (win & FORM_MASK[FORM]) == FORM_PATTERN[FORM];
		res.good = (win >= FORM_FLOOR[FORM]) && in_range;
		res.cp   = cp;
	end

endmodule

`default_nettype wire

/* sv/utf8wd_merge.sv */
//------------------------------------------------------------------------------
// utf8wd_merge
// Picks the form whose pattern matched, falls back to U+FFFD, returns 0 when
// at_end is set, and works out the consumed length and the next offset.
//------------------------------------------------------------------------------
`default_nettype none

module utf8wd_merge
	import utf8wd_pkg::*;
#(
	parameter int unsigned OFFSET_BITS = 16
) (
	input  wire lane_res_t        lanes [LANES],
	input  wire logic             at_end,
	input  wire logic [OFF_W-1:0] start_offset,
	output logic [CP_W-1:0]       code_point,
	output logic [LEN_W-1:0]      consumed_length,
	output logic                  replaced,
	output logic [OFF_W-1:0]      next_offset
);

	localparam logic [OFF_W-1:0] OFF_MASK = (OFFSET_BITS >= OFF_W) ? '1
		: OFF_W'((64'd1 << OFFSET_BITS) - 64'd1);

	logic             found;
	logic [OFF_W:0]   sum;

	always_comb begin
		found           = 1'b0;
		code_point      = REPLACEMENT;
		consumed_length = LEN_W'(1);
		replaced        = 1'b1;
		for (int k = 0; k < LANES; k++) begin
			if (!found && lanes[k].hit) begin
				found = 1'b1;
				if (lanes[k].good) begin
					code_point      = lanes[k].cp;
					consumed_length = LEN_W'(k + 1);
					replaced        = 1'b0;
				end
			end
		end
		if (at_end) begin
			code_point      = '0;
			consumed_length = '0;
			replaced        = 1'b0;
		end
		sum         = {1'b0, start_offset} + (OFF_W + 1)'(consumed_length);
		next_offset = sum[OFF_W-1:0] & OFF_MASK;
	end

endmodule

`default_nettype wire
